// ===== hdl/arcd_pkg.sv =====
`default_nettype none
package arcd_pkg;
  localparam int unsigned IndexBits = 32;

  typedef enum logic [3:0] {
    PH_ALEN, PH_AFLAG_LO, PH_AFLAG_HI, PH_AFILL, PH_ALIT, PH_CLEN, PH_CFLAG,
    PH_CDELTA_LO, PH_CDELTA_HI, PH_CFILL, PH_CLIT, PH_DONE, PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ALPHA = 2'd0, KIND_COLOUR = 2'd1, KIND_DONE = 2'd2, KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_RESERVED = 2'd1, ERR_TRUNC = 2'd2
  } err_e;

  // Action handed from the parser to the writer.
  typedef enum logic [2:0] {
    OP_NONE, OP_AFILL, OP_ALIT, OP_CDELTA, OP_CFILL, OP_CLIT, OP_CSTART, OP_RESTART
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] value;   // alpha byte, delta word, or blue/green
    logic [7:0]  red;
    logic [15:0] count;   // run length
    logic        fin;     // trailing finished/error result
    err_e        err;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] first;
    logic [15:0] run;
    logic [7:0]  alpha;
    logic [23:0] colour;
    err_e        err;
  } res_t;
endpackage
`default_nettype wire

// ===== hdl/arcd_front.sv =====
`default_nettype none
module arcd_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic [7:0]   byte_i,
  input  wire logic         start_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i,
  output arcd_pkg::cmd_t    cmd_o
);
  import arcd_pkg::*;

  phase_e      ph_q, ph_d;
  logic [31:0] left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic [14:0] cnt_q, cnt_d;
  logic [15:0] held_q, held_d;
  cmd_t        cmd_q, cmd_d;
  logic        cv_q, cv_d;

  phase_e      ph;
  logic [31:0] left, lnew;
  logic [1:0]  idx;
  logic [14:0] cnt;
  cmd_t        c;
  logic [15:0] flag;

  assign ready_o     = !cv_q || cmd_ready_i;
  assign cmd_valid_o = cv_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    ph = ph_q; left = left_q; idx = idx_q; cnt = cnt_q;
    if (start_i) begin
      ph = PH_ALEN; left = '0; idx = '0; cnt = '0;
    end
    ph_d = ph; left_d = left; idx_d = idx; cnt_d = cnt; held_d = held_q;
    c = '0; c.op = OP_NONE; c.err = ERR_NONE;
    // new image: back end clears its pixel counters and colour
    if (start_i) c.op = OP_RESTART;
    flag = {byte_i, held_q[7:0]};
    lnew = '0;
    if (ph == PH_DONE || ph == PH_HALT) begin
      ph_d = ph;
    end else if (ph == PH_ALEN || ph == PH_CLEN) begin
      lnew = (idx == 2'd0) ? 32'd0 : left;
      lnew = lnew | ({24'd0, byte_i} << {idx, 3'b000});
      left_d = lnew;
      if (idx != 2'd3) begin
        idx_d = idx + 2'd1;
      end else begin
        idx_d = '0;
        if (ph == PH_ALEN) begin
          ph_d = (lnew != 0) ? PH_AFLAG_LO : PH_CLEN;
        end else begin
          c.op = OP_CSTART;
          if (lnew != 0) ph_d = PH_CFLAG;
          else begin
            c.fin = 1'b1; ph_d = PH_DONE;
          end
        end
      end
    end else begin
      left_d = left - 32'd1;
      unique case (ph)
        PH_AFLAG_LO: begin
          held_d = {8'd0, byte_i}; ph_d = PH_AFLAG_HI;
        end
        PH_AFLAG_HI: begin
          cnt_d = flag[14:0];
          if (flag[15]) ph_d = PH_AFILL;
          else ph_d = (flag[14:0] != 0) ? PH_ALIT : PH_AFLAG_LO;
        end
        PH_AFILL: begin
          c.op = OP_AFILL; c.value = {8'd0, ~byte_i};
          c.count = {1'b0, cnt} + 16'd1;
          cnt_d = '0; ph_d = PH_AFLAG_LO;
        end
        PH_ALIT: begin
          c.op = OP_ALIT; c.value = {8'd0, ~byte_i}; c.count = 16'd1;
          cnt_d = cnt - 15'd1;
          if (cnt_d == 0) ph_d = PH_AFLAG_LO;
        end
        PH_CFLAG: begin
          idx_d = '0;
          unique case (byte_i[7:6])
            2'b10: begin
              cnt_d = {9'd0, byte_i[5:0]};
              ph_d = (byte_i[5:0] != 0) ? PH_CDELTA_LO : PH_CFLAG;
            end
            2'b01: begin
              cnt_d = {9'd0, byte_i[5:0]} + 15'd1; ph_d = PH_CFILL;
            end
            2'b00: begin
              cnt_d = {7'd0, byte_i};
              ph_d = (byte_i != 0) ? PH_CLIT : PH_CFLAG;
            end
            default: begin
              c.fin = 1'b1; c.err = ERR_RESERVED; ph_d = PH_HALT;
            end
          endcase
        end
        PH_CDELTA_LO: begin
          held_d = {8'd0, byte_i}; ph_d = PH_CDELTA_HI;
        end
        PH_CDELTA_HI: begin
          c.op = OP_CDELTA; c.value = flag; c.count = 16'd1;
          cnt_d = cnt - 15'd1;
          ph_d = (cnt_d != 0) ? PH_CDELTA_LO : PH_CFLAG;
        end
        PH_CFILL, PH_CLIT: begin
          if (idx == 2'd0) begin
            held_d = {8'd0, byte_i}; idx_d = 2'd1;
          end else if (idx == 2'd1) begin
            held_d = {byte_i, held_q[7:0]}; idx_d = 2'd2;
          end else begin
            idx_d = '0; c.value = held_q; c.red = byte_i;
            if (ph == PH_CFILL) begin
              c.op = OP_CFILL; c.count = {1'b0, cnt}; cnt_d = '0; ph_d = PH_CFLAG;
            end else begin
              c.op = OP_CLIT; c.count = 16'd1; cnt_d = cnt - 15'd1;
              ph_d = (cnt_d != 0) ? PH_CLIT : PH_CFLAG;
            end
          end
        end
        default: ph_d = ph;
      endcase
      if (ph_d != PH_HALT && left_d == 0) begin
        if (ph_d == PH_AFLAG_LO || ph_d == PH_ALIT) begin
          cnt_d = '0; idx_d = '0; ph_d = PH_CLEN;
        end else if (ph_d == PH_CFLAG) begin
          c.fin = 1'b1; ph_d = PH_DONE;
        end else begin
          c.fin = 1'b1; c.err = ERR_TRUNC; ph_d = PH_HALT;
        end
      end
    end
    cmd_d = c;
    cv_d  = (c.op != OP_NONE) || c.fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_ALEN; left_q <= '0; idx_q <= '0; cnt_q <= '0; held_q <= '0;
      cv_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      ph_q <= ph_d; left_q <= left_d; idx_q <= idx_d; cnt_q <= cnt_d;
      held_q <= held_d; cv_q <= cv_d;
    end else if (cmd_ready_i) begin
      cv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) cmd_q <= cmd_d;
  end
endmodule
`default_nettype wire

// ===== hdl/arcd_queue.sv =====
`default_nettype none
module arcd_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  arcd_pkg::cmd_t  in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output arcd_pkg::cmd_t  out_o
);
  import arcd_pkg::*;

  cmd_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] n_q;
  logic       push, pop;

  assign in_ready_o  = n_q != 3'd4;
  assign out_valid_o = n_q != 3'd0;
  assign out_o       = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; n_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      n_q <= n_q + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end
endmodule
`default_nettype wire

// ===== hdl/arcd_back.sv =====
`default_nettype none
module arcd_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_ready_o,
  input  arcd_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output arcd_pkg::res_t  res_o
);
  import arcd_pkg::*;

  logic [IndexBits-1:0] aidx_q, aidx_d, cidx_q, cidx_d;
  logic [23:0] col_q, col_d;
  res_t        r_q, r_d;
  logic        rv_q;
  logic        second_q, second_d;   // finish word still owed for this command
  logic        has_w;
  logic [7:0]  b, g, rr;
  logic [15:0] dw;
  logic        take, emit;

  function automatic logic [7:0] chan(input logic [7:0] cv, input logic [4:0] d,
                                      input logic pos5);
    logic [7:0] m;
    m = pos5 ? {3'd0, d} : {4'd0, d[3:0]};
    return (pos5 || !d[4]) ? cv + m : cv - m;
  endfunction

  assign has_w = cmd_i.op != OP_NONE && cmd_i.op != OP_CSTART && cmd_i.op != OP_RESTART;
  assign emit  = !rv_q || res_ready_i;
  assign cmd_ready_o = emit && (second_q || !(has_w && cmd_i.fin));
  assign take  = cmd_valid_i && emit;
  assign res_valid_o = rv_q;
  assign res_o = r_q;

  always_comb begin
    aidx_d = aidx_q; cidx_d = cidx_q; col_d = col_q; second_d = second_q;
    r_d = '0; r_d.kind = KIND_DONE; r_d.err = ERR_NONE;
    dw = cmd_i.value;
    b = chan(col_q[7:0], dw[4:0], dw[15]);
    g = chan(col_q[15:8], dw[9:5], dw[15]);
    rr = chan(col_q[23:16], dw[14:10], dw[15]);
    if (second_q || !has_w) begin
      if (cmd_i.op == OP_CSTART) begin
        cidx_d = '0; col_d = '0;
      end else if (cmd_i.op == OP_RESTART) begin
        aidx_d = '0; cidx_d = '0; col_d = '0;
      end
      r_d.kind = (cmd_i.err == ERR_NONE) ? KIND_DONE : KIND_ERROR;
      r_d.err = cmd_i.err;
      second_d = 1'b0;
    end else begin
      r_d.run = cmd_i.count;
      second_d = cmd_i.fin;
      if (cmd_i.op == OP_AFILL || cmd_i.op == OP_ALIT) begin
        r_d.kind = KIND_ALPHA; r_d.first = 32'(aidx_q); r_d.alpha = cmd_i.value[7:0];
        aidx_d = aidx_q + IndexBits'(cmd_i.count);
      end else begin
        r_d.kind = KIND_COLOUR; r_d.first = 32'(cidx_q);
        if (cmd_i.op == OP_CDELTA) col_d = {rr, g, b};
        else col_d = {cmd_i.red, cmd_i.value};
        r_d.colour = col_d;
        cidx_d = cidx_q + IndexBits'(cmd_i.count);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aidx_q <= '0; cidx_q <= '0; col_q <= '0; rv_q <= 1'b0; second_q <= 1'b0;
    end else if (take) begin
      aidx_q <= aidx_d; cidx_q <= cidx_d; col_q <= col_d; second_q <= second_d;
      rv_q <= has_w || cmd_i.fin || second_q;
      // a bare colour-section start emits nothing
      if (!second_q && cmd_i.op == OP_CSTART && !cmd_i.fin) rv_q <= 1'b0;
    end else if (res_ready_i) begin
      rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) r_q <= r_d;
  end
endmodule
`default_nettype wire

// ===== hdl/alpha_rle_and_colour_delta_decoder_top.sv =====
`default_nettype none
// Alpha run-length / colour delta image decoder.
// Input channel: one compressed byte per word (data_byte_i), with
// stream_start_i marking the first byte of a new image; accepted when
// in_valid_i and in_ready_o are both high.
// Output channel: one pixel-run write, finish or error per word, accepted
// when out_valid_o and out_ready_i are both high.
// Throughput: one input byte per clock while no stage stalls; a byte that yields
// both a write and a finish/error costs the back end a second result word.
// A byte reaches the output through the parser register, the 4-entry
// command queue and the result register.
// The parser front end tracks section lengths and tokens; the back end
// holds the pixel counters and last colour and forms results.
// Reset clears parser, queue and counters; the decoder then awaits the
// alpha section length. When the receiver stalls, the result register
// holds, the queue fills, then in_ready_o drops; no word is lost.
module alpha_rle_and_colour_delta_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        stream_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [31:0]      first_pixel_o,
  output logic [15:0]      run_length_o,
  output logic [7:0]       alpha_value_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       green_o,
  output logic [7:0]       red_o,
  output logic [1:0]       error_code_o
);
  import arcd_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_v, f_r, q_v, q_r;
  res_t res;

  arcd_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o),
    .byte_i(data_byte_i), .start_i(stream_start_i),
    .cmd_valid_o(f_v), .cmd_ready_i(f_r), .cmd_o(f_cmd)
  );

  arcd_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_v), .in_ready_o(f_r), .in_i(f_cmd),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(q_cmd)
  );

  arcd_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_v), .cmd_ready_o(q_r), .cmd_i(q_cmd),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign result_kind_o = res.kind;
  assign first_pixel_o = res.first;
  assign run_length_o  = res.run;
  assign alpha_value_o = res.alpha;
  assign blue_o        = res.colour[7:0];
  assign green_o       = res.colour[15:8];
  assign red_o         = res.colour[23:16];
  assign error_code_o  = res.err;
endmodule
`default_nettype wire
